// ----- design/building_light_dimmer_channel_assert.svh -----
// ----------------------------------------------------------------------------
// Dimmer channel assertion macros
// Shared property forms for the concurrent checks in the dimmer channel RTL.
// ----------------------------------------------------------------------------
`ifndef BUILDING_LIGHT_DIMMER_CHANNEL_ASSERT_SVH
`define BUILDING_LIGHT_DIMMER_CHANNEL_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BLDC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, when true, forces another condition in the next cycle.
`define BLDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/bldc_pkg.sv -----
// ----------------------------------------------------------------------------
// Dimmer channel package
// Types, codes and constants shared by the dimmer channel modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bldc_pkg;

   // Input transaction opcodes. The two remaining codes start no action, but a switch-off timer may still arm.
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_SWITCH  = 3'd1,
      OP_DIM     = 3'd2,
      OP_LEVEL   = 3'd3,
      OP_BLOCK   = 3'd4,
      OP_RESTART = 3'd5
   } op_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_STEP_PERIOD      = 3'd0,
      CSR_SOFT_ON_PERIOD   = 3'd1,
      CSR_SOFT_OFF_PERIOD  = 3'd2,
      CSR_LEVEL_SELECT     = 3'd3,
      CSR_OFF_THRESHOLD    = 3'd4,
      CSR_OFF_DELAY        = 3'd5,
      CSR_BASIC_BRIGHTNESS = 3'd6,
      CSR_MODE_FLAGS       = 3'd7
   } csr_index_type;

   // Bit positions inside mode_flags.
   localparam int MODE_OFF_ENABLE = 0;
   localparam int MODE_POLARITY   = 1;
   localparam int MODE_JUMP       = 2;

   // Level list: entries below LIST_LAST come from the table.
   localparam logic [3:0] LIST_LAST    = 4'd12;
   localparam logic [3:0] LIST_CURRENT = 4'd14;
   localparam logic [7:0] LIST_TABLE [12] = '{
      8'd0, 8'd1, 8'd25, 8'd51, 8'd76, 8'd102,
      8'd127, 8'd153, 8'd178, 8'd204, 8'd229, 8'd255
   };

   // Drive curve constants, in 1/128 level units.
   localparam logic [14:0] FULL_DRIVE = 15'd32640;
   localparam logic [14:0] CURVE_SPAN = 15'd32314;
   localparam logic [14:0] CURVE_KNEE = 15'd325;
   localparam logic [14:0] CURVE_BASE = 15'd326;

   // Reciprocal of CURVE_SPAN, applied to the top 16 bits of the product.
   localparam logic [16:0] RECIP_MULT  = 17'd66456;
   localparam int          RECIP_SHIFT = 17;

   typedef struct packed {
      logic [15:0] step_period;
      logic [15:0] soft_on_period;
      logic [15:0] soft_off_period;
      logic [15:0] level_select;
      logic [7:0]  off_threshold;
      logic [15:0] off_delay;
      logic [14:0] basic_brightness;
      logic [2:0]  mode_flags;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      step_period:      16'd1,
      soft_on_period:   16'd0,
      soft_off_period:  16'd0,
      level_select:     16'd0,
      off_threshold:    8'd0,
      off_delay:        16'd0,
      basic_brightness: 15'd128,
      mode_flags:       3'd0
   };

   typedef struct packed {
      logic [7:0]  level;
      logic [7:0]  previous_level;
      logic [7:0]  last_output_level;
      logic [7:0]  target_level;
      logic        dim_up;
      logic        dim_down;
      logic        off_run;
      logic        blocked;
      logic        switch_state;
      logic [15:0] step_cnt;
      logic [15:0] step_reload;
      logic [15:0] off_cnt;
   } dim_state_type;

   typedef struct packed {
      logic changed;
      logic sw_valid;
      logic sw;
      logic lv_valid;
   } report_type;

   // Feedback fields that ride alongside the drive value down the pipeline.
   typedef struct packed {
      report_type rp;
      logic [7:0] level_report;
   } side_type;

   // Load enables of the drive mapping stages.
   typedef struct packed {
      logic load2;
      logic load3;
      logic load4;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// ----- design/bldc_core.sv -----
// ----------------------------------------------------------------------------
// Dimmer channel state update
// Applies one transaction to the channel state and registers its feedback.
// ----------------------------------------------------------------------------
`default_nettype none
`include "building_light_dimmer_channel_assert.svh"

module bldc_core import bldc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       update,
   input  wire logic       load,
   input  wire logic [2:0] opcode,
   input  wire logic [7:0] value,
   output logic [7:0]      out_level,
   output side_type        side
);

   typedef struct packed {
      dim_state_type st;
      report_type    rp;
   } step_type;

   dim_state_type state_ff;
   dim_state_type state_in;
   logic [7:0]    out_level_ff;
   logic [7:0]    out_level_in;
   side_type      side_ff;
   side_type      side_in;

   function automatic logic [7:0] list_level(logic [3:0] idx, dim_state_type s);
      logic [7:0] r;
      if (idx < LIST_LAST) begin
         r = LIST_TABLE[idx];
      end else if (idx == LIST_LAST) begin
         r = s.last_output_level;
      end else if (idx == LIST_CURRENT) begin
         r = s.level;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   function automatic dim_state_type stop_all(dim_state_type s);
      s.dim_up   = 1'b0;
      s.dim_down = 1'b0;
      s.off_run  = 1'b0;
      return s;
   endfunction

   function automatic dim_state_type start_toward(dim_state_type s, logic [7:0] tgt,
                                                  logic [15:0] period);
      s.target_level = tgt;
      s.step_reload  = period;
      s.dim_up       = tgt > s.level;
      s.dim_down     = tgt < s.level;
      s.step_cnt     = '0;
      return s;
   endfunction

   function automatic dim_state_type switch_action(dim_state_type s, cfg_type c);
      logic [7:0] t;
      t = list_level(c.level_select[3:0], s);
      if (s.switch_state) begin
         if (c.soft_on_period == '0) begin
            s.level = t;
         end else begin
            s = start_toward(s, t, c.soft_on_period);
         end
      end else begin
         if (c.soft_off_period == '0) begin
            s.level = '0;
         end else begin
            s = start_toward(s, 8'd0, c.soft_off_period);
         end
      end
      return s;
   endfunction

   function automatic step_type update_output(step_type x);
      if (x.st.level != x.st.previous_level) begin
         x.st.last_output_level = x.st.level;
         x.rp.changed = 1'b1;
         if (x.st.previous_level == '0) begin
            x.rp.sw_valid       = 1'b1;
            x.rp.sw             = 1'b1;
            x.st.switch_state   = 1'b1;
         end
         if (x.st.level == '0) begin
            x.rp.sw_valid       = 1'b1;
            x.rp.sw             = 1'b0;
            x.st.switch_state   = 1'b0;
         end
         if (!x.st.dim_up && !x.st.dim_down) begin
            x.rp.lv_valid = 1'b1;
         end
         x.st.previous_level = x.st.level;
      end
      return x;
   endfunction

   function automatic step_type blocking_event(step_type x, logic b, cfg_type c);
      x.st = stop_all(x.st);
      if (b != c.mode_flags[MODE_POLARITY]) begin
         x.st.level   = list_level(c.level_select[11:8], x.st);
         x            = update_output(x);
         x.st.blocked = 1'b1;
      end else begin
         x.st.level   = list_level(c.level_select[15:12], x.st);
         x.st.blocked = 1'b0;
      end
      return x;
   endfunction

   always_comb begin
      step_type   x;
      logic [2:0] k;
      logic [7:0] steps;
      logic [7:0] tgt;
      x.st = state_ff;
      x.rp = '0;
      k    = value[2:0];
      steps = 8'hFF >> (k - 3'd1);
      tgt  = '0;

      unique case (opcode)
         OP_TICK: begin
            if (x.st.dim_up || x.st.dim_down) begin
               if (x.st.step_cnt <= 16'd1) begin
                  if (x.st.dim_up) begin
                     if (x.st.level != 8'hFF) begin
                        x.st.level = x.st.level + 8'd1;
                     end
                     if (x.st.level < x.st.target_level) begin
                        x.st.step_cnt = x.st.step_reload;
                     end else begin
                        x.st = stop_all(x.st);
                     end
                  end else begin
                     if (x.st.level != 8'h00) begin
                        x.st.level = x.st.level - 8'd1;
                     end
                     if (x.st.level > x.st.target_level) begin
                        x.st.step_cnt = x.st.step_reload;
                     end else begin
                        x.st = stop_all(x.st);
                     end
                  end
               end else begin
                  x.st.step_cnt = x.st.step_cnt - 16'd1;
               end
            end
            // An expiring switch-off timer acts as a switch-off, blocked or not.
            if (x.st.off_run) begin
               if (x.st.off_cnt <= 16'd1) begin
                  x.st = stop_all(x.st);
                  x.st.switch_state = 1'b0;
                  x.st = switch_action(x.st, cfg);
               end else begin
                  x.st.off_cnt = x.st.off_cnt - 16'd1;
               end
            end
         end
         OP_SWITCH: begin
            if (value[0] != x.st.switch_state && !x.st.blocked) begin
               x.st = stop_all(x.st);
               x.st.switch_state = value[0];
               x.st = switch_action(x.st, cfg);
            end
         end
         OP_DIM: begin
            if (k != 3'd0) begin
               if (value[3]) begin
                  tgt = ((8'hFF - x.st.level) > steps) ? x.st.level + steps : 8'hFF;
               end else begin
                  tgt = (x.st.level > steps) ? x.st.level - steps : 8'h00;
               end
               x.st = start_toward(x.st, tgt, cfg.step_period);
            end else begin
               x.st = stop_all(x.st);
               x.rp.lv_valid = 1'b1;
            end
         end
         OP_LEVEL: begin
            x.st = stop_all(x.st);
            if (cfg.mode_flags[MODE_JUMP]) begin
               x.st.level = value;
            end else begin
               x.st = start_toward(x.st, value, cfg.step_period);
            end
         end
         OP_BLOCK: begin
            x = blocking_event(x, value[0], cfg);
         end
         OP_RESTART: begin
            x = blocking_event(x, 1'b0, cfg);
            x.st.level = list_level(cfg.level_select[7:4], x.st);
            // Force a mismatch so the bus-on level is reported unless the channel is left blocked.
            x.st.previous_level = (x.st.level == '0) ? 8'd1 : 8'd0;
         end
         default: begin
         end
      endcase

      if (!x.st.blocked) begin
         x = update_output(x);
      end

      if (x.st.level < cfg.off_threshold && cfg.mode_flags[MODE_OFF_ENABLE] &&
          !x.st.dim_up && !x.st.dim_down && !x.st.off_run) begin
         x.st.off_cnt = cfg.off_delay;
         x.st.off_run = 1'b1;
      end

      state_in             = x.st;
      out_level_in         = x.st.last_output_level;
      side_in.rp           = x.rp;
      side_in.rp.sw        = x.rp.sw_valid && x.rp.sw;
      side_in.level_report = x.rp.lv_valid ? x.st.level : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_level_ff <= out_level_in;
         side_ff      <= side_in;
      end
   end

   assign out_level = out_level_ff;
   assign side      = side_ff;

   `BLDC_ASSERT_ALWAYS(a_dim_direction_exclusive, clock, reset,
      !(state_ff.dim_up && state_ff.dim_down), "dim runs both ways")
   `BLDC_ASSERT_ALWAYS(a_dim_short_of_target, clock, reset,
      (!state_ff.dim_up || state_ff.level < state_ff.target_level) &&
      (!state_ff.dim_down || state_ff.level > state_ff.target_level),
      "running dim already at target")
   `BLDC_ASSERT_NEXT(a_state_holds_between_items, clock, reset,
      !update, $stable(state_ff), "channel state changed without a transaction")

endmodule

`default_nettype wire

// ----- design/bldc_drive_map.sv -----
// ----------------------------------------------------------------------------
// Dimmer channel drive mapping
// Three-stage pipeline mapping the output level onto the brightness curve.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_drive_map import bldc_pkg::*; (
   input  wire logic         clock,
   input  wire logic [14:0]  basic_brightness,
   input  wire pipe_ctl_type ctl,
   input  wire logic [7:0]   level,
   input  wire side_type     side_in,
   output logic [14:0]       drive_value,
   output side_type          side_out
);

   // Stage 2: product of the remaining span and the level above the curve base.
   logic [14:0] ov;
   logic [14:0] b_eff;
   logic [14:0] diff;
   logic [14:0] span;
   logic [29:0] prod_in;
   logic [29:0] prod2_ff;
   logic [14:0] ov2_ff;
   logic [14:0] b2_ff;
   logic        low2_ff;
   side_type    side2_ff;

   // Stage 3: quotient estimate, at most one below the exact quotient.
   logic [32:0] est_full;
   logic [14:0] q_est_in;
   logic [14:0] q_est3_ff;
   logic [29:0] prod3_ff;
   logic [14:0] ov3_ff;
   logic [14:0] b3_ff;
   logic        low3_ff;
   side_type    side3_ff;

   // Stage 4: correction and output register.
   logic [29:0] back;
   logic [29:0] rem;
   logic [14:0] q;
   logic [14:0] drive_in;
   logic [14:0] drive_ff;
   side_type    side4_ff;

   assign ov      = {level, 7'b0};
   assign b_eff   = (basic_brightness > FULL_DRIVE) ? FULL_DRIVE : basic_brightness;
   assign diff    = FULL_DRIVE - b_eff;
   assign span    = ov - CURVE_BASE;
   assign prod_in = 30'(diff) * 30'(span);

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         prod2_ff <= prod_in;
         ov2_ff   <= ov;
         b2_ff    <= b_eff;
         low2_ff  <= ov <= CURVE_KNEE;
         side2_ff <= side_in;
      end
   end

   assign est_full = 33'(prod2_ff[29:14]) * 33'(RECIP_MULT);
   assign q_est_in = est_full[RECIP_SHIFT+14:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         q_est3_ff <= q_est_in;
         prod3_ff  <= prod2_ff;
         ov3_ff    <= ov2_ff;
         b3_ff     <= b2_ff;
         low3_ff   <= low2_ff;
         side3_ff  <= side2_ff;
      end
   end

   assign back     = 30'(q_est3_ff) * 30'(CURVE_SPAN);
   assign rem      = prod3_ff - back;
   assign q        = q_est3_ff + 15'(rem >= 30'(CURVE_SPAN));
   assign drive_in = low3_ff ? ov3_ff : q + b3_ff;

   always_ff @(posedge clock) begin
      if (ctl.load4) begin
         drive_ff <= drive_in;
         side4_ff <= side3_ff;
      end
   end

   assign drive_value = drive_ff;
   assign side_out    = side4_ff;

endmodule

`default_nettype wire

// ----- design/building_light_dimmer_channel.sv -----
// ----------------------------------------------------------------------------
// Dimmer channel top level
// One light dimmer channel with its configuration registers and pipeline.
// ----------------------------------------------------------------------------
// Usage: one instance drives one dimmer channel. Each req_ transaction
// (tick, switch, relative dim, absolute level, blocking or restart) yields
// exactly one rsp_ transaction carrying the mapped drive value and the
// switch and brightness feedback caused by that request.
// A request passes five registers from accept to response valid: the
// input register, the state update, and three stages of drive curve
// arithmetic (one multiply, then a reciprocal multiply, then a
// correction step). Each stage holds one request.
// Throughput is one transaction per cycle while rsp_stall is low.
// When rsp_stall is high the output register holds, the stages behind it
// keep filling, and req_stall rises only once all five stages are full.
// Configuration registers are written through the csr_ port, which is
// ready whenever reset is low; write them only while no request is in flight.
// A synchronous reset clears the channel state and loads the register
// defaults; the block takes requests in the cycle after reset falls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "building_light_dimmer_channel_assert.svh"

module building_light_dimmer_channel import bldc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [14:0]      rsp_drive_value,
   output logic             rsp_drive_changed,
   output logic             rsp_switch_report_valid,
   output logic             rsp_switch_report,
   output logic             rsp_level_report_valid,
   output logic [7:0]       rsp_level_report,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic [4:0]   valid_ff;
   logic [4:0]   valid_in;
   logic [4:0]   free;
   logic [2:0]   opcode_ff;
   logic [7:0]   value_ff;
   logic         update;
   pipe_ctl_type ctl;
   logic [7:0]   core_level;
   side_type     core_side;
   side_type     rsp_side;

   // Configuration writes.
   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_PERIOD:      cfg_in.step_period      = csr_data;
            CSR_SOFT_ON_PERIOD:   cfg_in.soft_on_period   = csr_data;
            CSR_SOFT_OFF_PERIOD:  cfg_in.soft_off_period  = csr_data;
            CSR_LEVEL_SELECT:     cfg_in.level_select     = csr_data;
            CSR_OFF_THRESHOLD:    cfg_in.off_threshold    = csr_data[7:0];
            CSR_OFF_DELAY:        cfg_in.off_delay        = csr_data;
            CSR_BASIC_BRIGHTNESS: cfg_in.basic_brightness = csr_data[14:0];
            CSR_MODE_FLAGS:       cfg_in.mode_flags       = csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A stage may load when it is empty or its contents move on this cycle.
   assign free[4] = !valid_ff[4] || !rsp_stall;
   assign free[3] = !valid_ff[3] || free[4];
   assign free[2] = !valid_ff[2] || free[3];
   assign free[1] = !valid_ff[1] || free[2];
   assign free[0] = !valid_ff[0] || free[1];

   assign req_stall = reset || !free[0];
   assign update    = valid_ff[0] && free[1];

   always_comb begin
      valid_in[0] = free[0] ? req_valid   : valid_ff[0];
      valid_in[1] = free[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = free[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = free[3] ? valid_ff[2] : valid_ff[3];
      valid_in[4] = free[4] ? valid_ff[3] : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free[0]) begin
         opcode_ff <= req_opcode;
         value_ff  <= req_value;
      end
   end

   assign ctl.load2 = free[2];
   assign ctl.load3 = free[3];
   assign ctl.load4 = free[4];

   bldc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .update    (update),
      .load      (free[1]),
      .opcode    (opcode_ff),
      .value     (value_ff),
      .out_level (core_level),
      .side      (core_side)
   );

   bldc_drive_map u_drive_map (
      .clock            (clock),
      .basic_brightness (cfg_ff.basic_brightness),
      .ctl              (ctl),
      .level            (core_level),
      .side_in          (core_side),
      .drive_value      (rsp_drive_value),
      .side_out         (rsp_side)
   );

   assign rsp_valid               = valid_ff[4];
   assign rsp_drive_changed       = rsp_side.rp.changed;
   assign rsp_switch_report_valid = rsp_side.rp.sw_valid;
   assign rsp_switch_report       = rsp_side.rp.sw;
   assign rsp_level_report_valid  = rsp_side.rp.lv_valid;
   assign rsp_level_report        = rsp_side.level_report;

   `BLDC_ASSERT_ALWAYS(a_stall_only_when_full, clock, reset,
      !req_stall || (&valid_ff), "request stalled with a free stage")
   `BLDC_ASSERT_NEXT(a_output_refills, clock, reset,
      valid_ff[3] && !valid_ff[4], valid_ff[4], "empty output stage not refilled")

endmodule

`default_nettype wire

// ----- tb/sv/building_light_dimmer_channel_tb.sv -----
// ----------------------------------------------------------------------------
// Dimmer channel testbench
// Drives tick, switch, dim, level, blocking and restart transactions into one
// dimmer channel under random idle and stall. A built-in channel model
// predicts each response no opening row pins; all are compared field by field.
// ----------------------------------------------------------------------------
module building_light_dimmer_channel_tb;
   import bldc_pkg::*;

   // The two opcodes that start no action in the channel.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam int NUM_OPENING     = 23;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 68;
   localparam int CALM_PHASE      = 5;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRINT_LIMIT     = 40;
   localparam int IDLE_PERCENT    = 28;

   typedef struct packed {
      logic [14:0] drive;
      logic        changed;
      logic        sw_valid;
      logic        sw;
      logic        lv_valid;
      logic [7:0]  lv;
   } drive_report_type;

   typedef struct packed {
      logic [2:0]       op;
      logic [7:0]       val;
      logic             pinned;
      drive_report_type want;
   } opening_row_type;

   localparam drive_report_type QUIET_REPORT = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = OP_TICK;
   logic [7:0]  req_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_drive_value;
   logic        rsp_drive_changed;
   logic        rsp_switch_report_valid;
   logic        rsp_switch_report;
   logic        rsp_level_report_valid;
   logic [7:0]  rsp_level_report;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_STEP_PERIOD;
   logic [15:0] csr_data = 16'd0;

   // Typed expectation that travels with the request payload.
   logic             pin_valid = 1'b0;
   drive_report_type pin_want = '0;
   logic             calm_window = 1'b0;

   drive_report_type pending_reports [$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;

   // Model state of the channel.
   cfg_type     cfg_shadow;
   logic [7:0]  lvl, prev_lvl, shown_lvl, goal_lvl;
   logic        ramp_up, ramp_down, auto_off_armed, held, lamp_on;
   logic [15:0] step_left, step_reload_v, off_left;
   report_type  flags;

   opening_row_type opening_rows [NUM_OPENING] = '{
      '{OP_TICK,    8'h00, 1'b1, QUIET_REPORT},
      '{OP_DIM,     8'h00, 1'b1, '{15'd0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0}},
      '{OP_DIM,     8'h09, 1'b0, QUIET_REPORT},
      '{OP_TICK,    8'h00, 1'b1, '{15'd128, 1'b1, 1'b1, 1'b1, 1'b0, 8'd0}},
      '{OP_TICK,    8'h00, 1'b1, '{15'd256, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0}},
      '{OP_TICK,    8'h00, 1'b0, QUIET_REPORT},
      '{OP_DIM,     8'hF0, 1'b0, QUIET_REPORT},
      '{OP_DIM,     8'h0F, 1'b0, QUIET_REPORT},
      '{OP_DIM,     8'h01, 1'b0, QUIET_REPORT},
      '{OP_TICK,    8'h00, 1'b0, QUIET_REPORT},
      '{OP_TICK,    8'h00, 1'b0, QUIET_REPORT},
      '{OP_LEVEL,   8'hFF, 1'b0, QUIET_REPORT},
      '{OP_SPARE_A, 8'hFF, 1'b0, QUIET_REPORT},
      '{OP_SPARE_B, 8'h00, 1'b0, QUIET_REPORT},
      '{OP_TICK,    8'h00, 1'b0, QUIET_REPORT},
      '{OP_SWITCH,  8'h00, 1'b0, QUIET_REPORT},
      '{OP_SWITCH,  8'hFF, 1'b0, QUIET_REPORT},
      '{OP_BLOCK,   8'h01, 1'b0, QUIET_REPORT},
      '{OP_SWITCH,  8'h00, 1'b0, QUIET_REPORT},
      '{OP_LEVEL,   8'h80, 1'b0, QUIET_REPORT},
      '{OP_TICK,    8'h00, 1'b0, QUIET_REPORT},
      '{OP_BLOCK,   8'h00, 1'b0, QUIET_REPORT},
      '{OP_RESTART, 8'hFF, 1'b0, QUIET_REPORT}
   };

   building_light_dimmer_channel dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_opcode              (req_opcode),
      .req_value               (req_value),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_drive_value         (rsp_drive_value),
      .rsp_drive_changed       (rsp_drive_changed),
      .rsp_switch_report_valid (rsp_switch_report_valid),
      .rsp_switch_report       (rsp_switch_report),
      .rsp_level_report_valid  (rsp_level_report_valid),
      .rsp_level_report        (rsp_level_report),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Channel model
   // ------------------------------------------------------------------------
   function automatic void model_reset();
      cfg_shadow = CFG_RESET;
      lvl = 8'd0;
      prev_lvl = 8'd0;
      shown_lvl = 8'd0;
      goal_lvl = 8'd0;
      ramp_up = 1'b0;
      ramp_down = 1'b0;
      auto_off_armed = 1'b0;
      held = 1'b0;
      lamp_on = 1'b0;
      step_left = 16'd0;
      step_reload_v = 16'd0;
      off_left = 16'd0;
   endfunction

   function automatic logic [7:0] list_pick(logic [3:0] idx);
      if (idx < LIST_LAST) return LIST_TABLE[idx];
      if (idx == LIST_LAST) return shown_lvl;
      if (idx == LIST_CURRENT) return lvl;
      return 8'd0;
   endfunction

   function automatic void halt_ramps();
      ramp_up = 1'b0;
      ramp_down = 1'b0;
      auto_off_armed = 1'b0;
   endfunction

   function automatic void ramp_toward(logic [7:0] tgt, logic [15:0] period);
      goal_lvl = tgt;
      step_reload_v = period;
      ramp_up = tgt > lvl;
      ramp_down = tgt < lvl;
      step_left = 16'd0;
   endfunction

   function automatic void publish_level();
      if (lvl != prev_lvl) begin
         shown_lvl = lvl;
         flags.changed = 1'b1;
         if (prev_lvl == 8'd0) begin
            flags.sw_valid = 1'b1;
            flags.sw = 1'b1;
            lamp_on = 1'b1;
         end
         if (lvl == 8'd0) begin
            flags.sw_valid = 1'b1;
            flags.sw = 1'b0;
            lamp_on = 1'b0;
         end
         if (!ramp_up && !ramp_down) flags.lv_valid = 1'b1;
         prev_lvl = lvl;
      end
   endfunction

   function automatic void follow_switch();
      logic [7:0] on_lvl;
      on_lvl = list_pick(cfg_shadow.level_select[3:0]);
      if (lamp_on) begin
         if (cfg_shadow.soft_on_period == 16'd0) lvl = on_lvl;
         else ramp_toward(on_lvl, cfg_shadow.soft_on_period);
      end else begin
         if (cfg_shadow.soft_off_period == 16'd0) lvl = 8'd0;
         else ramp_toward(8'd0, cfg_shadow.soft_off_period);
      end
   endfunction

   function automatic void apply_block(logic bit0);
      halt_ramps();
      if (bit0 != cfg_shadow.mode_flags[MODE_POLARITY]) begin
         lvl = list_pick(cfg_shadow.level_select[11:8]);
         publish_level();
         held = 1'b1;
      end else begin
         lvl = list_pick(cfg_shadow.level_select[15:12]);
         held = 1'b0;
      end
   endfunction

   function automatic void run_tick();
      if (ramp_up || ramp_down) begin
         if (step_left <= 16'd1) begin
            if (ramp_up) begin
               if (lvl != 8'hFF) lvl = lvl + 8'd1;
               if (lvl < goal_lvl) step_left = step_reload_v;
               else halt_ramps();
            end else begin
               if (lvl != 8'h00) lvl = lvl - 8'd1;
               if (lvl > goal_lvl) step_left = step_reload_v;
               else halt_ramps();
            end
         end else begin
            step_left = step_left - 16'd1;
         end
      end
      // The automatic switch-off acts like a switch-off transaction, even
      // while the channel is blocked.
      if (auto_off_armed) begin
         if (off_left <= 16'd1) begin
            halt_ramps();
            lamp_on = 1'b0;
            follow_switch();
         end else begin
            off_left = off_left - 16'd1;
         end
      end
   endfunction

   function automatic logic [14:0] drive_of(logic [7:0] lv);
      int unsigned raw, floor_v;
      raw = 32'(lv) * 32'd128;
      if (raw > 32'(CURVE_KNEE)) begin
         floor_v = (cfg_shadow.basic_brightness > FULL_DRIVE) ? 32'(FULL_DRIVE)
                                                               : 32'(cfg_shadow.basic_brightness);
         raw = (32'(FULL_DRIVE) - floor_v) * (raw - 32'(CURVE_BASE)) / 32'(CURVE_SPAN)
               + floor_v;
      end
      return 15'(raw);
   endfunction

   function automatic drive_report_type dimmer_update(logic [2:0] op, logic [7:0] val);
      drive_report_type res;
      int unsigned      span, aim;
      logic [3:0]       nib;
      flags = '0;
      nib = val[3:0];
      case (op)
         OP_SWITCH: begin
            if (val[0] != lamp_on && !held) begin
               halt_ramps();
               lamp_on = val[0];
               follow_switch();
            end
         end
         OP_DIM: begin
            if (nib[2:0] != 3'd0) begin
               span = 32'd255 >> (32'(nib[2:0]) - 32'd1);
               if (nib[3]) aim = (32'd255 - lvl > span) ? lvl + span : 32'd255;
               else aim = (lvl > span) ? lvl - span : 32'd0;
               ramp_toward(8'(aim), cfg_shadow.step_period);
            end else begin
               halt_ramps();
               flags.lv_valid = 1'b1;
            end
         end
         OP_LEVEL: begin
            halt_ramps();
            if (cfg_shadow.mode_flags[MODE_JUMP]) lvl = val;
            else ramp_toward(val, cfg_shadow.step_period);
         end
         OP_BLOCK: apply_block(val[0]);
         OP_RESTART: begin
            apply_block(1'b0);
            lvl = list_pick(cfg_shadow.level_select[7:4]);
            // Force a difference so that the bus-on level is reported unless the channel is left blocked.
            prev_lvl = (lvl == 8'd0) ? 8'd1 : 8'd0;
         end
         default: ;
      endcase
      if (op == OP_TICK) run_tick();
      if (!held) publish_level();
      if (lvl < cfg_shadow.off_threshold && cfg_shadow.mode_flags[MODE_OFF_ENABLE] &&
          !ramp_up && !ramp_down && !auto_off_armed) begin
         off_left = cfg_shadow.off_delay;
         auto_off_armed = 1'b1;
      end
      res.drive = drive_of(shown_lvl);
      res.changed = flags.changed;
      res.sw_valid = flags.sw_valid;
      res.sw = flags.sw_valid & flags.sw;
      res.lv_valid = flags.lv_valid;
      res.lv = flags.lv_valid ? lvl : 8'd0;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_report(drive_report_type got, drive_report_type want);
      if (got.drive !== want.drive)
         flag_mismatch($sformatf("drive_value %0d, want %0d", got.drive, want.drive));
      if (got.changed !== want.changed)
         flag_mismatch($sformatf("drive_changed %0b, want %0b", got.changed, want.changed));
      if (got.sw_valid !== want.sw_valid)
         flag_mismatch($sformatf("switch_report_valid %0b, want %0b",
                                 got.sw_valid, want.sw_valid));
      if (got.sw !== want.sw)
         flag_mismatch($sformatf("switch_report %0b, want %0b", got.sw, want.sw));
      if (got.lv_valid !== want.lv_valid)
         flag_mismatch($sformatf("level_report_valid %0b, want %0b",
                                 got.lv_valid, want.lv_valid));
      if (got.lv !== want.lv)
         flag_mismatch($sformatf("level_report %0d, want %0d", got.lv, want.lv));
   endtask

   // All handshakes are sampled at the clock edge, before any register moves.
   always @(posedge clock) begin : watch
      drive_report_type got, calc;
      logic             moved;
      if (reset) begin
         model_reset();
         pending_reports.delete();
         quiet_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_STEP_PERIOD:      cfg_shadow.step_period = csr_data;
               CSR_SOFT_ON_PERIOD:   cfg_shadow.soft_on_period = csr_data;
               CSR_SOFT_OFF_PERIOD:  cfg_shadow.soft_off_period = csr_data;
               CSR_LEVEL_SELECT:     cfg_shadow.level_select = csr_data;
               CSR_OFF_THRESHOLD:    cfg_shadow.off_threshold = csr_data[7:0];
               CSR_OFF_DELAY:        cfg_shadow.off_delay = csr_data;
               CSR_BASIC_BRIGHTNESS: cfg_shadow.basic_brightness = csr_data[14:0];
               CSR_MODE_FLAGS:       cfg_shadow.mode_flags = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            calc = dimmer_update(req_opcode, req_value);
            pending_reports.push_back(pin_valid ? pin_want : calc);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = '{rsp_drive_value, rsp_drive_changed, rsp_switch_report_valid,
                    rsp_switch_report, rsp_level_report_valid, rsp_level_report};
            if (pending_reports.size() == 0) flag_mismatch("response with nothing expected");
            else compare_report(got, pending_reports.pop_front());
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   always @(posedge clock)
      rsp_stall <= !reset && !calm_window && ($urandom_range(99) < IDLE_PERCENT);

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic send_item(logic [2:0] op, logic [7:0] val, logic pinned,
                            drive_report_type want);
      while (!calm_window && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value <= val;
      pin_valid <= pinned;
      pin_want <= want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(csr_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Waits until every expected response is in, then lets the pipe settle.
   task automatic drain();
      do @(posedge clock); while (pending_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int phase);
      if (phase == 0) begin
         csr_write(CSR_STEP_PERIOD, 16'd1);
         csr_write(CSR_SOFT_ON_PERIOD, 16'd0);
         csr_write(CSR_SOFT_OFF_PERIOD, 16'd0);
         csr_write(CSR_LEVEL_SELECT, 16'd0);
         csr_write(CSR_OFF_THRESHOLD, 16'd0);
         csr_write(CSR_OFF_DELAY, 16'd0);
         csr_write(CSR_BASIC_BRIGHTNESS, 16'd0);
         csr_write(CSR_MODE_FLAGS, 16'd0);
      end else if (phase == 1) begin
         csr_write(CSR_STEP_PERIOD, 16'hFFFF);
         csr_write(CSR_SOFT_ON_PERIOD, 16'hFFFF);
         csr_write(CSR_SOFT_OFF_PERIOD, 16'hFFFF);
         csr_write(CSR_LEVEL_SELECT, 16'hFFFF);
         csr_write(CSR_OFF_THRESHOLD, 16'd255);
         csr_write(CSR_OFF_DELAY, 16'hFFFF);
         csr_write(CSR_BASIC_BRIGHTNESS, 16'h7FFF);
         csr_write(CSR_MODE_FLAGS, 16'd7);
      end else begin
         // Short periods keep dims and the switch-off timer moving.
         csr_write(CSR_STEP_PERIOD, 16'($urandom_range(3)));
         csr_write(CSR_SOFT_ON_PERIOD,
                   ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(3)));
         csr_write(CSR_SOFT_OFF_PERIOD,
                   ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(3)));
         csr_write(CSR_LEVEL_SELECT, 16'($urandom()));
         csr_write(CSR_OFF_THRESHOLD, 16'($urandom_range(255)));
         csr_write(CSR_OFF_DELAY, 16'($urandom_range(5)));
         csr_write(CSR_BASIC_BRIGHTNESS, 16'($urandom_range(32767)));
         csr_write(CSR_MODE_FLAGS, 16'($urandom_range(7)));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [2:0] pick_opcode();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) return OP_TICK;
      if (roll < 57) return OP_SWITCH;
      if (roll < 72) return OP_DIM;
      if (roll < 84) return OP_LEVEL;
      if (roll < 91) return OP_BLOCK;
      if (roll < 95) return OP_RESTART;
      if (roll < 97) return OP_SPARE_A;
      return OP_SPARE_B;
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_rows[i])
         send_item(opening_rows[i].op, opening_rows[i].val, opening_rows[i].pinned,
                   opening_rows[i].want);
      req_valid <= 1'b0;
      drain();
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         configure(phase);
         calm_window <= (phase == CALM_PHASE);
         repeat (ITEMS_PER_PHASE)
            send_item(pick_opcode(), 8'($urandom_range(255)), 1'b0, QUIET_REPORT);
         req_valid <= 1'b0;
         drain();
      end
      if (mismatch_count == 0) $display("building_light_dimmer_channel_tb: clean");
      else $display("building_light_dimmer_channel_tb: errors");
      $finish;
   end

   // Ends a run in which no transaction of any kind moves for too long.
   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("building_light_dimmer_channel_tb: errors");
      $finish;
   end

endmodule
